>>> rtl/dual_plate_center_of_pressure_defines.svh
// Assertion macros shared by the dual-plate center of pressure RTL.
`ifndef DUAL_PLATE_CENTER_OF_PRESSURE_DEFINES_SVH
`define DUAL_PLATE_CENTER_OF_PRESSURE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/dpcop_pkg.sv
// Types and constants shared by the dual-plate center of pressure blocks.
package dpcop_pkg;

    localparam int POS_W   = 20;
    localparam int FORCE_W = 16;
    localparam int TOTAL_W = 19;
    localparam int PSUM_W  = 18;

    localparam logic [POS_W-1:0]        POS_MAX_BITS = 20'h7FFFF;
    localparam logic [POS_W-1:0]        POS_MIN_BITS = 20'h80000;
    localparam logic [TOTAL_W-1:0]      HALF_FORCE   = 19'd8;

    localparam logic signed [POS_W-1:0] CFG_A_X_RST  = -20'sd4000;
    localparam logic signed [POS_W-1:0] CFG_A_Y_RST  = 20'sd0;
    localparam logic signed [POS_W-1:0] CFG_B_X_RST  = 20'sd4000;
    localparam logic signed [POS_W-1:0] CFG_B_Y_RST  = 20'sd0;

    // Input item kind
    typedef enum logic [1:0] {
        KIND_A    = 2'd0,
        KIND_B    = 2'd1,
        KIND_ZERO = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // Result channel
    typedef enum logic [1:0] {
        CH_LEFT  = 2'd0,
        CH_RIGHT = 2'd1,
        CH_COMB  = 2'd2
    } t_channel;

    // Configuration register index
    typedef enum logic [1:0] {
        CFG_A_X = 2'd0,
        CFG_A_Y = 2'd1,
        CFG_B_X = 2'd2,
        CFG_B_Y = 2'd3
    } t_cfg_index;

    typedef enum logic {
        JOB_PAIR = 1'b0,
        JOB_ZERO = 1'b1
    } t_job_kind;

    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_SUM   = 4'd1,
        S_MUL   = 4'd2,
        S_NUM   = 4'd3,
        S_ABS   = 4'd4,
        S_OVF   = 4'd5,
        S_DIV   = 4'd6,
        S_FIN   = 4'd7,
        S_LEFT  = 4'd8,
        S_RIGHT = 4'd9,
        S_COMB  = 4'd10
    } t_back_state;

    typedef struct packed {
        logic signed [POS_W-1:0]     pos_x;
        logic signed [POS_W-1:0]     pos_y;
        logic [3:0][FORCE_W-1:0]     frc;
    } t_plate;

    typedef struct packed {
        t_job_kind kind;
        t_plate    a;
        t_plate    b;
    } t_job;

    typedef struct packed {
        t_channel                    channel;
        logic [POS_W-1:0]            x;
        logic [POS_W-1:0]            y;
        logic [3:0][FORCE_W-1:0]     frc;
        logic [TOTAL_W-1:0]          total;
        logic                        last;
    } t_result;

endpackage

>>> rtl/dual_plate_center_of_pressure.sv
// Combined center of pressure of two force plates: top level.
//
// Input channel (i_in_valid / o_in_stall): one beat is a plate A sample, a
// plate B sample or a zeroing command, chosen by i_kind. Plate samples are held
// until both plates have one; that beat releases a run of three result beats
// on the output channel (o_out_valid / i_out_stall): left, right, combined,
// with o_last high on the combined beat.
// The back end steps each pair through sum, product, numerator, magnitude and
// overflow states, the 20-step restoring divider for the combined position and
// a final saturation, then loads the left, right and combined beats in order,
// each held back by output stalls; it takes the next job only after the combined
// beat is loaded. Zeroing is done in the idle state and produces no beat.
// A job queue of QUEUE_DEPTH entries sits between front and back end, so
// input beats keep being taken while results wait; o_in_stall rises only when
// the queue is full. A stalled output beat holds in the output register.
// Configuration: i_cfg_we writes plate offset i_cfg_index with i_cfg_data.
// Reset clears the pending flags, the zero offset and the last combined
// position, and sets the plate A and B x offsets to -4000 and +4000.
module dual_plate_center_of_pressure #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [19:0] i_pos_x,
    input  logic [19:0] i_pos_y,
    input  logic [15:0] i_force_a,
    input  logic [15:0] i_force_b,
    input  logic [15:0] i_force_c,
    input  logic [15:0] i_force_d,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_channel,
    output logic [19:0] o_out_x,
    output logic [19:0] o_out_y,
    output logic [15:0] o_out_force_a,
    output logic [15:0] o_out_force_b,
    output logic [15:0] o_out_force_c,
    output logic [15:0] o_out_force_d,
    output logic [18:0] o_total_force,
    output logic        o_last
);

    dpcop_pkg::t_plate  in_plate;
    dpcop_pkg::t_job    push_job;
    dpcop_pkg::t_job    head_job;
    dpcop_pkg::t_result result;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    // Gather the sample fields
    assign in_plate.pos_x  = i_pos_x;
    assign in_plate.pos_y  = i_pos_y;
    assign in_plate.frc[0] = i_force_a;
    assign in_plate.frc[1] = i_force_b;
    assign in_plate.frc[2] = i_force_c;
    assign in_plate.frc[3] = i_force_d;

    dpcop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_plate    (in_plate),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    dpcop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    dpcop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_head    (head_job),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (result)
    );

    // Split the result beat into its fields
    assign o_channel     = result.channel;
    assign o_out_x       = result.x;
    assign o_out_y       = result.y;
    assign o_out_force_a = result.frc[0];
    assign o_out_force_b = result.frc[1];
    assign o_out_force_c = result.frc[2];
    assign o_out_force_d = result.frc[3];
    assign o_total_force = result.total;
    assign o_last        = result.last;

endmodule

>>> rtl/dpcop_front.sv
// Front end: accepts beats, holds plate samples and issues pair and zeroing jobs.
module dpcop_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  dpcop_pkg::t_plate  i_plate,
    input  logic               i_q_full,
    output logic               o_push,
    output dpcop_pkg::t_job    o_job
);

    dpcop_pkg::t_plate r_a, n_a;
    dpcop_pkg::t_plate r_b, n_b;
    logic              r_pend_a, n_pend_a;
    logic              r_pend_b, n_pend_b;
    logic              accept;

    // Take a beat whenever the job queue has room
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Classify the beat: hold the sample, emit a job once both plates are pending
    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_pend_a = r_pend_a;
        n_pend_b = r_pend_b;
        o_push   = 1'b0;
        o_job    = '{kind: dpcop_pkg::JOB_PAIR, a: r_a, b: r_b};
        if (accept) begin
            case (dpcop_pkg::t_kind'(i_kind))
                dpcop_pkg::KIND_A: begin
                    n_a      = i_plate;
                    n_pend_a = 1'b1;
                    if (r_pend_b) begin
                        o_push   = 1'b1;
                        o_job.a  = i_plate;
                        n_pend_a = 1'b0;
                        n_pend_b = 1'b0;
                    end
                end
                dpcop_pkg::KIND_B: begin
                    n_b      = i_plate;
                    n_pend_b = 1'b1;
                    if (r_pend_a) begin
                        o_push   = 1'b1;
                        o_job.b  = i_plate;
                        n_pend_a = 1'b0;
                        n_pend_b = 1'b0;
                    end
                end
                dpcop_pkg::KIND_ZERO: begin
                    o_push     = 1'b1;
                    o_job.kind = dpcop_pkg::JOB_ZERO;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // Pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_a <= 1'b0;
            r_pend_b <= 1'b0;
        end else begin
            r_pend_a <= n_pend_a;
            r_pend_b <= n_pend_b;
        end
    end

    // Held samples
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

endmodule

>>> rtl/dpcop_queue.sv
// Short job queue between the front end and the arithmetic back end.
`include "dual_plate_center_of_pressure_defines.svh"

module dpcop_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dpcop_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output dpcop_pkg::t_job   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dpcop_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

>>> rtl/dpcop_back.sv
// Back end: sums forces, divides for the combined position and emits three results.
`include "dual_plate_center_of_pressure_defines.svh"

module dpcop_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [19:0]              i_cfg_data,
    input  logic                     i_q_empty,
    input  dpcop_pkg::t_job          i_q_head,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output dpcop_pkg::t_result       o_out
);

    localparam int NUM_W = 41;
    localparam int QUO_W = 20;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(QUO_W - 1);

    dpcop_pkg::t_back_state r_state, n_state;
    dpcop_pkg::t_job        r_job;
    dpcop_pkg::t_result     r_out, n_out;
    logic                   r_out_valid;
    logic                   out_free;
    logic                   out_load;

    logic signed [19:0] r_off_ax, r_off_ay, r_off_bx, r_off_by;
    logic signed [19:0] r_zero_x, r_zero_y;
    logic signed [19:0] r_last_x, r_last_y;

    logic [dpcop_pkg::PSUM_W-1:0]  r_za, r_zb;
    logic [dpcop_pkg::TOTAL_W-1:0] r_total, r_div;
    logic signed [20:0]            r_sax, r_say, r_sbx, r_sby;
    logic signed [39:0]            r_pax, r_pay, r_pbx, r_pby;
    logic signed [NUM_W-1:0]       r_num_x, r_num_y;
    logic                          r_neg_x, r_neg_y;
    logic                          r_ovf_x, r_ovf_y;
    logic [NUM_W-1:0]              r_rem_x, r_rem_y;
    logic [NUM_W-1:0]              r_dsh;
    logic [QUO_W-1:0]              r_qm_x, r_qm_y;
    logic [CNT_W-1:0]              r_cnt;

    logic [dpcop_pkg::PSUM_W-1:0]  za, zb;
    logic                          ge_x, ge_y;

    // Position minus zero offset, saturated to 20 bits
    function automatic logic [19:0] sat_diff(input logic signed [19:0] a,
                                             input logic signed [19:0] b);
        logic [20:0] d;
        d = {a[19], a} - {b[19], b};
        if (d[20] != d[19]) begin
            sat_diff = d[20] ? dpcop_pkg::POS_MIN_BITS : dpcop_pkg::POS_MAX_BITS;
        end else begin
            sat_diff = d[19:0];
        end
    endfunction

    // Signed quotient from magnitude, sign and overflow, saturated to 20 bits
    function automatic logic [19:0] sat_quot(input logic neg, input logic ovf,
                                             input logic [19:0] m);
        if (!neg) begin
            sat_quot = (ovf || m[19]) ? dpcop_pkg::POS_MAX_BITS : m;
        end else if (ovf || (m > dpcop_pkg::POS_MIN_BITS)) begin
            sat_quot = dpcop_pkg::POS_MIN_BITS;
        end else begin
            sat_quot = ~m + 20'd1;
        end
    endfunction

    assign za = dpcop_pkg::PSUM_W'(r_job.a.frc[0]) + dpcop_pkg::PSUM_W'(r_job.a.frc[1])
              + dpcop_pkg::PSUM_W'(r_job.a.frc[2]) + dpcop_pkg::PSUM_W'(r_job.a.frc[3]);
    assign zb = dpcop_pkg::PSUM_W'(r_job.b.frc[0]) + dpcop_pkg::PSUM_W'(r_job.b.frc[1])
              + dpcop_pkg::PSUM_W'(r_job.b.frc[2]) + dpcop_pkg::PSUM_W'(r_job.b.frc[3]);

    // One restoring step per cycle on both axes
    assign ge_x = (r_rem_x >= r_dsh);
    assign ge_y = (r_rem_y >= r_dsh);

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpcop_pkg::S_IDLE: begin
                if (!i_q_empty && (i_q_head.kind == dpcop_pkg::JOB_PAIR)) begin
                    n_state = dpcop_pkg::S_SUM;
                end
            end
            dpcop_pkg::S_SUM: n_state = dpcop_pkg::S_MUL;
            dpcop_pkg::S_MUL: n_state = dpcop_pkg::S_NUM;
            dpcop_pkg::S_NUM: n_state = dpcop_pkg::S_ABS;
            dpcop_pkg::S_ABS: n_state = dpcop_pkg::S_OVF;
            dpcop_pkg::S_OVF: n_state = dpcop_pkg::S_DIV;
            dpcop_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = dpcop_pkg::S_FIN;
                end
            end
            dpcop_pkg::S_FIN: n_state = dpcop_pkg::S_LEFT;
            dpcop_pkg::S_LEFT: begin
                if (out_free) begin
                    n_state = dpcop_pkg::S_RIGHT;
                end
            end
            dpcop_pkg::S_RIGHT: begin
                if (out_free) begin
                    n_state = dpcop_pkg::S_COMB;
                end
            end
            dpcop_pkg::S_COMB: begin
                if (out_free) begin
                    n_state = dpcop_pkg::S_IDLE;
                end
            end
            default: n_state = dpcop_pkg::S_IDLE;
        endcase
    end

    // State outputs: queue pop and result beat selection
    always_comb begin
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        n_out    = '{channel: dpcop_pkg::CH_LEFT,
                     x: sat_diff(r_job.a.pos_x, r_zero_x),
                     y: sat_diff(r_job.a.pos_y, r_zero_y),
                     frc: r_job.a.frc, total: '0, last: 1'b0};
        case (r_state)
            dpcop_pkg::S_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            dpcop_pkg::S_LEFT: begin
                out_load = out_free;
            end
            dpcop_pkg::S_RIGHT: begin
                out_load      = out_free;
                n_out.channel = dpcop_pkg::CH_RIGHT;
                n_out.x       = sat_diff(r_job.b.pos_x, r_zero_x);
                n_out.y       = sat_diff(r_job.b.pos_y, r_zero_y);
                n_out.frc     = r_job.b.frc;
            end
            dpcop_pkg::S_COMB: begin
                out_load      = out_free;
                n_out.channel = dpcop_pkg::CH_COMB;
                n_out.x       = sat_diff(r_last_x, r_zero_x);
                n_out.y       = sat_diff(r_last_y, r_zero_y);
                n_out.frc     = '0;
                n_out.total   = r_total;
                n_out.last    = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control, offsets and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpcop_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_zero_x    <= '0;
            r_zero_y    <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_off_ax    <= dpcop_pkg::CFG_A_X_RST;
            r_off_ay    <= dpcop_pkg::CFG_A_Y_RST;
            r_off_bx    <= dpcop_pkg::CFG_B_X_RST;
            r_off_by    <= dpcop_pkg::CFG_B_Y_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // zeroing copies the last unoffset combined position
            if (o_q_pop && (i_q_head.kind == dpcop_pkg::JOB_ZERO)) begin
                r_zero_x <= r_last_x;
                r_zero_y <= r_last_y;
            end
            if (r_state == dpcop_pkg::S_FIN) begin
                r_last_x <= sat_quot(r_neg_x, r_ovf_x, r_qm_x);
                r_last_y <= sat_quot(r_neg_y, r_ovf_y, r_qm_y);
            end
            if (i_cfg_we) begin
                case (dpcop_pkg::t_cfg_index'(i_cfg_index))
                    dpcop_pkg::CFG_A_X: r_off_ax <= i_cfg_data;
                    dpcop_pkg::CFG_A_Y: r_off_ay <= i_cfg_data;
                    dpcop_pkg::CFG_B_X: r_off_bx <= i_cfg_data;
                    dpcop_pkg::CFG_B_Y: r_off_by <= i_cfg_data;
                    default:            r_off_ax <= r_off_ax;
                endcase
            end
        end
    end

    // Datapath: sums, products, numerator, magnitude, division
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
        case (r_state)
            dpcop_pkg::S_IDLE: begin
                if (o_q_pop) begin
                    r_job <= i_q_head;
                end
            end
            dpcop_pkg::S_SUM: begin
                r_za    <= za;
                r_zb    <= zb;
                r_total <= dpcop_pkg::TOTAL_W'(za) + dpcop_pkg::TOTAL_W'(zb);
                r_sax   <= {r_off_ax[19], r_off_ax} + {r_job.a.pos_x[19], r_job.a.pos_x};
                r_say   <= {r_off_ay[19], r_off_ay} + {r_job.a.pos_y[19], r_job.a.pos_y};
                r_sbx   <= {r_off_bx[19], r_off_bx} + {r_job.b.pos_x[19], r_job.b.pos_x};
                r_sby   <= {r_off_by[19], r_off_by} + {r_job.b.pos_y[19], r_job.b.pos_y};
            end
            dpcop_pkg::S_MUL: begin
                r_pax <= $signed({1'b0, r_za}) * r_sax;
                r_pay <= $signed({1'b0, r_za}) * r_say;
                r_pbx <= $signed({1'b0, r_zb}) * r_sbx;
                r_pby <= $signed({1'b0, r_zb}) * r_sby;
                // a light load divides by one half instead
                r_div <= (r_total > dpcop_pkg::HALF_FORCE) ? r_total : dpcop_pkg::HALF_FORCE;
            end
            dpcop_pkg::S_NUM: begin
                r_num_x <= {r_pax[39], r_pax} + {r_pbx[39], r_pbx};
                r_num_y <= {r_pay[39], r_pay} + {r_pby[39], r_pby};
            end
            dpcop_pkg::S_ABS: begin
                r_neg_x <= r_num_x[NUM_W-1];
                r_neg_y <= r_num_y[NUM_W-1];
                r_rem_x <= r_num_x[NUM_W-1] ? (~r_num_x + 1'b1) : r_num_x;
                r_rem_y <= r_num_y[NUM_W-1] ? (~r_num_y + 1'b1) : r_num_y;
            end
            dpcop_pkg::S_OVF: begin
                r_ovf_x <= (r_rem_x >= NUM_W'({r_div, 20'b0}));
                r_ovf_y <= (r_rem_y >= NUM_W'({r_div, 20'b0}));
                r_dsh   <= NUM_W'({r_div, 19'b0});
                r_qm_x  <= '0;
                r_qm_y  <= '0;
                r_cnt   <= CNT_TOP;
            end
            dpcop_pkg::S_DIV: begin
                if (ge_x) begin
                    r_rem_x <= r_rem_x - r_dsh;
                end
                if (ge_y) begin
                    r_rem_y <= r_rem_y - r_dsh;
                end
                r_qm_x <= {r_qm_x[QUO_W-2:0], ge_x};
                r_qm_y <= {r_qm_y[QUO_W-2:0], ge_y};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    `ASSERT_IMPLY(a_div_floor, i_clk, i_rst_n, r_state == dpcop_pkg::S_DIV, r_div >= dpcop_pkg::HALF_FORCE)
    `ASSERT_IMPLY(a_rem_x_below_div, i_clk, i_rst_n, (r_state == dpcop_pkg::S_FIN) && !r_ovf_x, r_rem_x < NUM_W'(r_div))
    `ASSERT_IMPLY(a_last_on_comb, i_clk, i_rst_n, r_out_valid && r_out.last, r_out.channel == dpcop_pkg::CH_COMB)

endmodule

>>> bench/dual_plate_center_of_pressure_checker.sv
// Beat checker for the dual-plate center of pressure block: prediction and comparison.
`timescale 1ns / 100ps

module dual_plate_center_of_pressure_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [19:0] i_pos_x,
    input  logic [19:0] i_pos_y,
    input  logic [15:0] i_force_a,
    input  logic [15:0] i_force_b,
    input  logic [15:0] i_force_c,
    input  logic [15:0] i_force_d,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_channel,
    input  logic [19:0] i_out_x,
    input  logic [19:0] i_out_y,
    input  logic [15:0] i_out_force_a,
    input  logic [15:0] i_out_force_b,
    input  logic [15:0] i_out_force_c,
    input  logic [15:0] i_out_force_d,
    input  logic [18:0] i_total_force,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        dpcop_pkg::t_channel                           channel;
        logic [dpcop_pkg::POS_W-1:0]                   x;
        logic [dpcop_pkg::POS_W-1:0]                   y;
        logic [3:0][dpcop_pkg::FORCE_W-1:0]            frc;
        logic [dpcop_pkg::TOTAL_W-1:0]                 total;
        logic                                          last;
    } t_cop_beat;

    // Plate offsets, held plate samples, zeroing state
    longint                             plate_offset[4];
    longint                             a_pos[2];
    longint                             b_pos[2];
    logic [3:0][dpcop_pkg::FORCE_W-1:0] a_frc;
    logic [3:0][dpcop_pkg::FORCE_W-1:0] b_frc;
    bit                                 a_pending;
    bit                                 b_pending;
    longint                             last_cop[2];
    longint                             zero_cop[2];
    t_cop_beat                          cop_beats_due[$];

    function automatic longint sext_pos(logic [dpcop_pkg::POS_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic t_cop_beat plate_beat(dpcop_pkg::t_channel ch, longint px, longint py,
                                             logic [3:0][dpcop_pkg::FORCE_W-1:0] frc);
        t_cop_beat b;
        b.channel = ch;
        b.x       = dpcop_pkg::POS_W'(clamp_pos(px - zero_cop[0]));
        b.y       = dpcop_pkg::POS_W'(clamp_pos(py - zero_cop[1]));
        b.frc     = frc;
        b.total   = '0;
        b.last    = 1'b0;
        return b;
    endfunction

    function automatic longint plate_sum(logic [3:0][dpcop_pkg::FORCE_W-1:0] frc);
        return longint'(frc[0]) + longint'(frc[1]) + longint'(frc[2]) + longint'(frc[3]);
    endfunction

    // Hold the sample; once both plates are held, queue left, right, combined
    task automatic take_sample_beat();
        logic [3:0][dpcop_pkg::FORCE_W-1:0] frc;
        longint                             za;
        longint                             zb;
        longint                             total;
        longint                             divisor;
        longint                             num;
        t_cop_beat                          comb;

        frc = {i_force_d, i_force_c, i_force_b, i_force_a};
        case (dpcop_pkg::t_kind'(i_kind))
            dpcop_pkg::KIND_ZERO: begin
                zero_cop[0] = last_cop[0];
                zero_cop[1] = last_cop[1];
                return;
            end
            dpcop_pkg::KIND_A: begin
                a_pos[0]  = sext_pos(i_pos_x);
                a_pos[1]  = sext_pos(i_pos_y);
                a_frc     = frc;
                a_pending = 1'b1;
            end
            dpcop_pkg::KIND_B: begin
                b_pos[0]  = sext_pos(i_pos_x);
                b_pos[1]  = sext_pos(i_pos_y);
                b_frc     = frc;
                b_pending = 1'b1;
            end
            default: return;
        endcase
        if (!(a_pending && b_pending))
            return;

        cop_beats_due.push_back(plate_beat(dpcop_pkg::CH_LEFT, a_pos[0], a_pos[1], a_frc));
        cop_beats_due.push_back(plate_beat(dpcop_pkg::CH_RIGHT, b_pos[0], b_pos[1], b_frc));

        // Force-weighted mean; light load divides by the half-unit floor
        za      = plate_sum(a_frc);
        zb      = plate_sum(b_frc);
        total   = za + zb;
        divisor = (total > longint'(dpcop_pkg::HALF_FORCE)) ?
                  total : longint'(dpcop_pkg::HALF_FORCE);
        for (int i = 0; i < 2; i++) begin
            num         = za * (plate_offset[i] + a_pos[i])
                        + zb * (plate_offset[2 + i] + b_pos[i]);
            last_cop[i] = clamp_pos(num / divisor);
        end
        comb         = plate_beat(dpcop_pkg::CH_COMB, last_cop[0], last_cop[1], '0);
        comb.total   = dpcop_pkg::TOTAL_W'(total);
        comb.last    = 1'b1;
        cop_beats_due.push_back(comb);
        a_pending = 1'b0;
        b_pending = 1'b0;
    endtask

    task automatic check_field(string name, longint want, longint seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            o_fail_count++;
        end
    endtask

    // Compare one output beat with the oldest due beat
    task automatic check_out_beat();
        t_cop_beat want;

        if (cop_beats_due.size() == 0) begin
            $error("unexpected output beat on channel %0d", i_channel);
            o_fail_count++;
            return;
        end
        want = cop_beats_due.pop_front();
        check_field("channel", want.channel, i_channel);
        check_field("out_x", sext_pos(want.x), sext_pos(i_out_x));
        check_field("out_y", sext_pos(want.y), sext_pos(i_out_y));
        check_field("out_force_a", want.frc[0], i_out_force_a);
        check_field("out_force_b", want.frc[1], i_out_force_b);
        check_field("out_force_c", want.frc[2], i_out_force_c);
        check_field("out_force_d", want.frc[3], i_out_force_d);
        check_field("total_force", want.total, i_total_force);
        check_field("last", want.last, i_last);
    endtask

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Track config writes, predict accepted inputs, check accepted outputs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plate_offset[dpcop_pkg::CFG_A_X] = longint'(dpcop_pkg::CFG_A_X_RST);
            plate_offset[dpcop_pkg::CFG_A_Y] = longint'(dpcop_pkg::CFG_A_Y_RST);
            plate_offset[dpcop_pkg::CFG_B_X] = longint'(dpcop_pkg::CFG_B_X_RST);
            plate_offset[dpcop_pkg::CFG_B_Y] = longint'(dpcop_pkg::CFG_B_Y_RST);
            for (int i = 0; i < 2; i++) begin
                a_pos[i]    = 0;
                b_pos[i]    = 0;
                last_cop[i] = 0;
                zero_cop[i] = 0;
            end
            a_frc     = '0;
            b_frc     = '0;
            a_pending = 1'b0;
            b_pending = 1'b0;
            cop_beats_due.delete();
        end else begin
            if (i_cfg_we)
                plate_offset[i_cfg_index] = sext_pos(i_cfg_data);
            if (i_in_valid && !i_in_stall)
                take_sample_beat();
            if (i_out_valid && !i_out_stall)
                check_out_beat();
        end
        o_outstanding = cop_beats_due.size();
    end

endmodule

>>> bench/tb.sv
// Testbench top for the dual-plate center of pressure block: stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int RUN_LIMIT   = 400000;
    localparam int SETTLE_WAIT = 64;
    localparam int PHASE_BEATS = 112;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = dpcop_pkg::CFG_A_X;
    logic [19:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind        = dpcop_pkg::KIND_NONE;
    logic [19:0] i_pos_x       = '0;
    logic [19:0] i_pos_y       = '0;
    logic [15:0] i_force_a     = '0;
    logic [15:0] i_force_b     = '0;
    logic [15:0] i_force_c     = '0;
    logic [15:0] i_force_d     = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [1:0]  o_channel;
    logic [19:0] o_out_x;
    logic [19:0] o_out_y;
    logic [15:0] o_out_force_a;
    logic [15:0] o_out_force_b;
    logic [15:0] o_out_force_c;
    logic [15:0] o_out_force_d;
    logic [18:0] o_total_force;
    logic        o_last;

    int fail_count;
    int beats_due;
    int sender_idle_pct   = 14;
    int receiver_stall_pct = 72;
    int cycle_count       = 0;

    dual_plate_center_of_pressure dut (.*);

    dual_plate_center_of_pressure_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_force_a     (i_force_a),
        .i_force_b     (i_force_b),
        .i_force_c     (i_force_c),
        .i_force_d     (i_force_d),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_channel     (o_channel),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_force_a (o_out_force_a),
        .i_out_force_b (o_out_force_b),
        .i_out_force_c (o_out_force_c),
        .i_out_force_d (o_out_force_d),
        .i_total_force (o_total_force),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (beats_due)
    );

    always #6 i_clk = ~i_clk;

    // Stall the output side at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one input beat after random idle cycles; hold it until taken
    task automatic send_beat(dpcop_pkg::t_kind kind, logic [19:0] px, logic [19:0] py,
                             logic [15:0] fa, logic [15:0] fb,
                             logic [15:0] fc, logic [15:0] fd);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_force_a  <= fa;
        i_force_b  <= fb;
        i_force_c  <= fc;
        i_force_d  <= fd;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Drop valid, drain all due beats, then let the back end settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (beats_due != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic configure(logic [19:0] ax, logic [19:0] ay,
                             logic [19:0] bx, logic [19:0] by);
        logic [19:0] vals[4];

        vals = '{ax, ay, bx, by};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= dpcop_pkg::t_cfg_index'(i);
            i_cfg_data  <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [19:0] rand_pos();
        case ($urandom_range(5))
            0:       return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
            1:       return 20'($signed($urandom_range(4000)) - 2000);
            default: return 20'($urandom());
        endcase
    endfunction

    // Send a plate sample with random position and one force profile
    task automatic send_plate(dpcop_pkg::t_kind kind);
        logic [15:0] frc[4];
        int          mode;

        mode = $urandom_range(9);
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0:       frc[i] = 16'($urandom_range(3));
                1:       frc[i] = 16'hFFFF;
                2:       frc[i] = 16'h0000;
                default: frc[i] = 16'($urandom());
            endcase
        end
        send_beat(kind, rand_pos(), rand_pos(), frc[0], frc[1], frc[2], frc[3]);
    endtask

    // Mostly complete pairs, with repeats, zeroing, lone samples and unused kinds
    task automatic play_random(int beat_total);
        int               sent;
        int               pick;
        dpcop_pkg::t_kind first;
        dpcop_pkg::t_kind second;

        sent = 0;
        while (sent < beat_total) begin
            pick   = $urandom_range(99);
            first  = $urandom_range(1) ? dpcop_pkg::KIND_A : dpcop_pkg::KIND_B;
            second = (first == dpcop_pkg::KIND_A) ? dpcop_pkg::KIND_B : dpcop_pkg::KIND_A;
            if (pick < 70) begin
                send_plate(first);
                send_plate(second);
                sent += 2;
            end else if (pick < 80) begin
                send_plate(first);
                send_plate(first);
                send_plate(second);
                sent += 3;
            end else if (pick < 88) begin
                send_beat(dpcop_pkg::KIND_ZERO, 20'($urandom()), 20'($urandom()),
                          16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
                sent += 1;
            end else if (pick < 93) begin
                send_beat(dpcop_pkg::KIND_NONE, 20'($urandom()), 20'($urandom()),
                          16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
                sent += 1;
            end else begin
                send_plate(first);
                sent += 1;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full-scale positions and forces, maximum total
        send_beat(dpcop_pkg::KIND_A, 20'h7FFFF, 20'h80000,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(dpcop_pkg::KIND_B, 20'h80000, 20'h7FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // No load, exactly the half-unit floor, and just above it
        send_beat(dpcop_pkg::KIND_A, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_B, 20'd100, -20'sd100, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_A, 20'd16, 20'd32, 16'd2, 16'd2, 16'd2, 16'd2);
        send_beat(dpcop_pkg::KIND_B, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_A, -20'sd16, 20'd48, 16'd2, 16'd2, 16'd2, 16'd3);
        send_beat(dpcop_pkg::KIND_B, 20'd5, 20'd5, 16'd0, 16'd0, 16'd0, 16'd0);
        // Combined position past full scale saturates
        send_beat(dpcop_pkg::KIND_A, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_B, 20'h7FFFF, 20'h7FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // A repeated sample replaces the held one
        send_beat(dpcop_pkg::KIND_A, 20'd1000, 20'd2000, 16'd10, 16'd20, 16'd30, 16'd40);
        send_beat(dpcop_pkg::KIND_A, -20'sd1000, -20'sd2000,
                  16'd50, 16'd60, 16'd70, 16'd80);
        send_beat(dpcop_pkg::KIND_B, 20'd300, 20'd400, 16'd5, 16'd6, 16'd7, 16'd8);
        // Plate B first, unused kind in between
        send_beat(dpcop_pkg::KIND_B, -20'sd300, -20'sd400, 16'd1, 16'd1, 16'd1, 16'd1);
        send_beat(dpcop_pkg::KIND_NONE, 20'h7FFFF, 20'h7FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(dpcop_pkg::KIND_A, 20'd700, 20'd800, 16'd9, 16'd9, 16'd9, 16'd9);
        // Zeroing, also while a plate is pending
        send_beat(dpcop_pkg::KIND_ZERO, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_A, 20'd1234, -20'sd4321,
                  16'd100, 16'd200, 16'd300, 16'd400);
        send_beat(dpcop_pkg::KIND_ZERO, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_B, -20'sd777, 20'd999,
                  16'd400, 16'd300, 16'd200, 16'd100);
        // Zero at high scale, then subtract it from low scale
        send_beat(dpcop_pkg::KIND_A, 20'h7FFFF, 20'h7FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(dpcop_pkg::KIND_B, 20'h7FFFF, 20'h7FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(dpcop_pkg::KIND_ZERO, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(dpcop_pkg::KIND_A, 20'h80000, 20'h80000, 16'd1, 16'd1, 16'd1, 16'd1);
        send_beat(dpcop_pkg::KIND_B, 20'h80000, 20'h80000, 16'd1, 16'd1, 16'd1, 16'd1);

        // Extreme offsets, sender idles lightly, receiver stalls heavily
        wait_idle();
        configure(20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000);
        play_random(PHASE_BEATS);

        // Random offsets, roles of idling swapped
        wait_idle();
        sender_idle_pct    = 72;
        receiver_stall_pct = 14;
        configure(20'($urandom()), 20'($urandom()), 20'($urandom()), 20'($urandom()));
        play_random(PHASE_BEATS);

        // Typical offsets, no idling on either side
        wait_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        configure(-20'sd6400, 20'd1200, 20'd6400, -20'sd1200);
        play_random(PHASE_BEATS);

        wait_idle();
        if (fail_count == 0 && beats_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
